@@ hw/rtl/drs_pkg.sv @@
// Shared types and constants for the delimiter record splitter.
// Used by drs_cell, drs_ctrl and the top level delimiter_record_splitter.
package drs_pkg;

   // Largest separator the window can hold (default for the top-level parameter)
   localparam int SEPARATOR_MAX_DEF = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_LEN_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIM_LENGTH      = 2'd2;

   localparam logic [CSR_DATA_W-1:0] SEPARATOR_BYTES_RST  = 64'd10;
   localparam logic [CSR_LEN_W-1:0]  SEPARATOR_LENGTH_RST = 4'd1;
   localparam logic [CSR_LEN_W-1:0]  TRIM_LENGTH_RST      = 4'd1;

   // Record count
   localparam int               TOTAL_W   = 24;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

   // Sequencer phase of the item under work
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ARRIVE,
      PH_EOR,
      PH_TAIL,
      PH_FLUSH
   } phase_type;

   // One result item
   typedef struct packed {
      logic [7:0]         out_byte;
      logic               byte_valid;
      logic               end_of_record;
      logic               end_of_buffer;
      logic [TOTAL_W-1:0] record_total;
   } result_type;

   // Per-cell window control
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

@@ hw/rtl/drs_cell.sv @@
// One byte cell of the separator window chain.
// Depends on drs_pkg for the cell control struct.
module drs_cell
   import drs_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic [7:0]   neighbour_byte,
   input  logic [7:0]   new_byte,
   input  logic [7:0]   sep_byte,
   output logic [7:0]   cell_byte,
   output logic         sep_hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // load the arriving byte, take the younger neighbour on a pop, else hold
   always_comb begin
      if (ctl.load) begin
         byte_in = new_byte;
      end else if (ctl.shift) begin
         byte_in = neighbour_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // compare the byte this cell will hold against its separator byte
   assign sep_hit   = (byte_in == sep_byte);
   assign cell_byte = byte_ff;

endmodule

@@ hw/rtl/drs_ctrl.sv @@
// Item register and result sequencer for the delimiter record splitter.
// Steers the window cells, counts records; depends on drs_pkg.
module drs_ctrl
   import drs_pkg::*;
#(
   parameter int SEPARATOR_MAX = SEPARATOR_MAX_DEF
)
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last_byte,
   input  logic                                 slot_free,
   input  logic [$clog2(SEPARATOR_MAX+1)-1:0]   sep_len,
   input  logic [$clog2(SEPARATOR_MAX+1)-1:0]   trim_len,
   input  logic [8*SEPARATOR_MAX-1:0]           sep_bytes,
   input  logic [7:0]                           oldest_byte,
   input  logic [SEPARATOR_MAX-1:0]             sep_hit,
   output cell_ctl_type                         cell_ctl [SEPARATOR_MAX],
   output logic [7:0]                           append_byte,
   output logic                                 emit,
   output result_type                           result
);

   localparam int FW = $clog2(SEPARATOR_MAX + 1);
   localparam int IW = (SEPARATOR_MAX > 1) ? $clog2(SEPARATOR_MAX) : 1;

   phase_type          phase_ff, phase_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [TOTAL_W-1:0] count_ff, count_in;
   logic [7:0]         item_byte_ff;
   logic               item_last_ff;

   logic               done;
   logic               shift;
   logic               append;
   logic [FW-1:0]      pos;
   logic [SEPARATOR_MAX-1:0] len_mask;
   logic               window_match;
   logic               new_full;
   logic [FW-1:0]      tail_next;
   logic [7:0]         tail_byte;
   logic [TOTAL_W-1:0] count_sat;
   logic [TOTAL_W-1:0] total;

   // cells that take part in the compare
   always_comb begin
      for (int i = 0; i < SEPARATOR_MAX; i++) begin
         len_mask[i] = (FW'(i) < sep_len);
      end
   end

   assign window_match = &(sep_hit | ~len_mask);
   assign new_full     = (fill_ff == sep_len) || ((fill_ff + FW'(1)) == sep_len);
   assign tail_next    = FW'(idx_ff) + FW'(1);
   assign tail_byte    = sep_bytes[{idx_ff, 3'b000} +: 8];
   assign count_sat    = (count_ff < TOTAL_MAX) ? count_ff + TOTAL_W'(1) : TOTAL_MAX;
   assign total        = count_sat;

   // window pops and the append slot; kept apart from the compare result
   always_comb begin
      shift  = 1'b0;
      append = 1'b0;
      pos    = fill_ff;
      if (slot_free) begin
         unique case (phase_ff)
            PH_ARRIVE: begin
               if (fill_ff > sep_len) begin
                  shift = 1'b1;
               end else begin
                  append = 1'b1;
                  if (fill_ff == sep_len) begin
                     shift = 1'b1;
                     pos   = fill_ff - FW'(1);
                  end
               end
            end
            PH_FLUSH: begin
               shift = (fill_ff != '0);
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer: at most one result per cycle
   always_comb begin
      phase_in = phase_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      emit     = 1'b0;
      result   = '0;
      done     = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            done = 1'b1;
         end
         PH_ARRIVE: begin
            if (slot_free) begin
               if (fill_ff > sep_len) begin
                  // window longer than the separator: drain oldest first
                  emit              = 1'b1;
                  result.out_byte   = oldest_byte;
                  result.byte_valid = 1'b1;
                  fill_in           = fill_ff - FW'(1);
               end else begin
                  if (fill_ff == sep_len) begin
                     // full window: oldest leaves while the new byte enters
                     emit              = 1'b1;
                     result.out_byte   = oldest_byte;
                     result.byte_valid = 1'b1;
                  end else begin
                     fill_in = fill_ff + FW'(1);
                  end
                  if (new_full && window_match) begin
                     fill_in  = '0;
                     count_in = count_sat;
                     phase_in = PH_EOR;
                  end else if (item_last_ff) begin
                     phase_in = PH_FLUSH;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
         end
         PH_EOR: begin
            if (slot_free) begin
               emit                 = 1'b1;
               result.end_of_record = 1'b1;
               if (trim_len == sep_len) begin
                  if (item_last_ff) begin
                     phase_in = PH_FLUSH;
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  idx_in   = trim_len[IW-1:0];
                  phase_in = PH_TAIL;
               end
            end
         end
         PH_TAIL: begin
            // untrimmed separator bytes open the next record
            if (slot_free) begin
               emit              = 1'b1;
               result.out_byte   = tail_byte;
               result.byte_valid = 1'b1;
               idx_in            = tail_next[IW-1:0];
               if (tail_next == sep_len) begin
                  if (item_last_ff) begin
                     phase_in = PH_FLUSH;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
         end
         PH_FLUSH: begin
            if (slot_free) begin
               emit = 1'b1;
               if (fill_ff != '0) begin
                  result.out_byte   = oldest_byte;
                  result.byte_valid = 1'b1;
                  fill_in           = fill_ff - FW'(1);
               end else begin
                  result.end_of_record = 1'b1;
                  result.end_of_buffer = 1'b1;
                  result.record_total  = total;
                  count_in             = '0;
                  done                 = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (done) begin
         phase_in = req_valid ? PH_ARRIVE : PH_IDLE;
      end
   end

   assign req_stall   = !done;
   assign append_byte = item_byte_ff;

   // window cell steering
   always_comb begin
      for (int i = 0; i < SEPARATOR_MAX; i++) begin
         cell_ctl[i].shift = shift;
         cell_ctl[i].load  = append && (pos == FW'(i));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         fill_ff  <= '0;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   // item register
   always_ff @(posedge clock) begin
      if (done && req_valid) begin
         item_byte_ff <= req_data_byte;
         item_last_ff <= req_last_byte;
      end
   end

endmodule

@@ hw/rtl/delimiter_record_splitter.sv @@
// Delimiter record splitter. Bytes enter one per item with a last-of-buffer
// flag and pass through a window of up to separator_length byte cells; when
// the window equals the separator a record closes (end_of_record item), and
// separator bytes from trim_length upwards open the next record. The final
// byte of a buffer flushes the window and ends with an end_of_buffer item
// carrying the saturated record count. An input item gives at most one
// result itself, so plain bytes flow one per cycle while the result is not
// stalled; each further result on the single result register holds off the
// next item: the end_of_record item and untrimmed bytes of a hit, the window
// bytes and end_of_buffer item of a buffer end, and each byte drained after
// the length shrank. A stalled result holds everything. An item's first
// result passes from the item register into the result register.
// Configuration writes are taken every cycle (csr_ready is always high) and
// must only be issued while idle. Depends on drs_pkg, drs_cell, drs_ctrl.
module delimiter_record_splitter
   import drs_pkg::*;
#(
   parameter int SEPARATOR_MAX = SEPARATOR_MAX_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   // input items
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   // result items
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_end_of_record,
   output logic                    rsp_end_of_buffer,
   output logic [TOTAL_W-1:0]      rsp_record_total,
   // configuration writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int FW = $clog2(SEPARATOR_MAX + 1);

   logic [CSR_DATA_W-1:0] sep_bytes_ff;
   logic [CSR_LEN_W-1:0]  sep_len_ff;
   logic [CSR_LEN_W-1:0]  trim_len_ff;
   logic [FW-1:0]         len_eff;
   logic [FW-1:0]         trim_eff;

   cell_ctl_type             cell_ctl [SEPARATOR_MAX];
   logic [7:0]               win   [SEPARATOR_MAX];
   logic [7:0]               nb    [SEPARATOR_MAX];
   logic [SEPARATOR_MAX-1:0] sep_hit;
   logic [7:0]               append_byte;

   logic       slot_free;
   logic       emit;
   result_type result;
   logic       rsp_valid_ff;
   result_type rsp_item_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_bytes_ff <= SEPARATOR_BYTES_RST;
         sep_len_ff   <= SEPARATOR_LENGTH_RST;
         trim_len_ff  <= TRIM_LENGTH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SEPARATOR_BYTES:  sep_bytes_ff <= csr_data;
            CSR_SEPARATOR_LENGTH: sep_len_ff   <= csr_data[CSR_LEN_W-1:0];
            CSR_TRIM_LENGTH:      trim_len_ff  <= csr_data[CSR_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // length clamped into 1..SEPARATOR_MAX
   always_comb begin
      if (sep_len_ff == '0) begin
         len_eff = FW'(1);
      end else if (sep_len_ff > CSR_LEN_W'(SEPARATOR_MAX)) begin
         len_eff = FW'(SEPARATOR_MAX);
      end else begin
         len_eff = sep_len_ff[FW-1:0];
      end
   end

   // trim clamped to the length
   always_comb begin
      if (trim_len_ff > CSR_LEN_W'(len_eff)) begin
         trim_eff = len_eff;
      end else begin
         trim_eff = trim_len_ff[FW-1:0];
      end
   end

   // window chain: cell 0 holds the oldest byte
   for (genvar i = 0; i < SEPARATOR_MAX; i++) begin : g_cell
      if (i == SEPARATOR_MAX - 1) begin : g_end
         assign nb[i] = 8'h00;
      end else begin : g_mid
         assign nb[i] = win[i+1];
      end

      drs_cell u_cell (
         .clock          (clock),
         .ctl            (cell_ctl[i]),
         .neighbour_byte (nb[i]),
         .new_byte       (append_byte),
         .sep_byte       (sep_bytes_ff[8*i +: 8]),
         .cell_byte      (win[i]),
         .sep_hit        (sep_hit[i])
      );
   end

   drs_ctrl #(
      .SEPARATOR_MAX (SEPARATOR_MAX)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .slot_free     (slot_free),
      .sep_len       (len_eff),
      .trim_len      (trim_eff),
      .sep_bytes     (sep_bytes_ff[8*SEPARATOR_MAX-1:0]),
      .oldest_byte   (win[0]),
      .sep_hit       (sep_hit),
      .cell_ctl      (cell_ctl),
      .append_byte   (append_byte),
      .emit          (emit),
      .result        (result)
   );

   // result register
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && emit) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_item_ff.out_byte;
   assign rsp_byte_valid    = rsp_item_ff.byte_valid;
   assign rsp_end_of_record = rsp_item_ff.end_of_record;
   assign rsp_end_of_buffer = rsp_item_ff.end_of_buffer;
   assign rsp_record_total  = rsp_item_ff.record_total;

endmodule

@@ test/delimiter_record_splitter_test.sv @@
// Self-checking testbench for delimiter_record_splitter: directed and random
// byte buffers against a behavioural splitter written in place. Depends on
// drs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module delimiter_record_splitter_test
   import drs_pkg::*;
();

   localparam int SEP_MAX        = SEPARATOR_MAX_DEF;
   localparam int ITEMS_TOTAL    = 460;
   localparam int RESET_CYCLES   = 12;
   localparam int DRAIN_CYCLES   = 10;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 3000;
   localparam int REPORT_LINES   = 100;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Block ports
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_byte_valid;
   logic                   rsp_end_of_record;
   logic                   rsp_end_of_buffer;
   logic [TOTAL_W-1:0]     rsp_record_total;
   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_data      = '0;

   delimiter_record_splitter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_end_of_record (rsp_end_of_record),
      .rsp_end_of_buffer (rsp_end_of_buffer),
      .rsp_record_total  (rsp_record_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Shared testbench state
   stream_byte_type pending_bytes[$];
   result_type      expected_results[$];
   int              error_count  = 0;
   int              queued_total = 0;
   int              idle_div     = 0;   // 1-in-N chance of starting a burst, 0 = none
   int              hold_request = 0;
   int              hold_served  = 0;

   // Splitter state and register copies
   logic [CSR_DATA_W-1:0] cfg_sep_bytes = SEPARATOR_BYTES_RST;
   logic [CSR_LEN_W-1:0]  cfg_sep_len   = SEPARATOR_LENGTH_RST;
   logic [CSR_LEN_W-1:0]  cfg_trim_len  = TRIM_LENGTH_RST;
   logic [7:0]            win_bytes [SEP_MAX];
   int                    win_fill   = 0;
   logic [TOTAL_W-1:0]    seps_found = '0;

   task automatic report_error(input string msg);
      if (error_count < REPORT_LINES)
         $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Effective separator length after clamping
   function automatic int sep_span();
      if (cfg_sep_len == 0)
         return 1;
      if (cfg_sep_len > SEP_MAX)
         return SEP_MAX;
      return int'(cfg_sep_len);
   endfunction

   task automatic emit_result(input logic [7:0] b, input logic v, input logic eor,
                              input logic eob, input logic [TOTAL_W-1:0] total);
      result_type r;
      r.out_byte      = b;
      r.byte_valid    = v;
      r.end_of_record = eor;
      r.end_of_buffer = eob;
      r.record_total  = total;
      expected_results.push_back(r);
   endtask

   // Oldest window byte leaves as record data
   task automatic release_oldest();
      int k;
      if (win_fill == 0)
         return;
      emit_result(win_bytes[0], 1'b1, 1'b0, 1'b0, '0);
      for (k = 1; k < win_fill; k++)
         win_bytes[k-1] = win_bytes[k];
      win_fill--;
   endtask

   // Expected results of one accepted byte
   task automatic split_byte(input logic [7:0] data_in, input logic last_in);
      int                 span;
      int                 trim;
      int                 k;
      bit                 hit;
      logic [TOTAL_W-1:0] total;
      span = sep_span();
      trim = (cfg_trim_len > span) ? span : int'(cfg_trim_len);
      if (win_fill == SEP_MAX)
         release_oldest();
      win_bytes[win_fill] = data_in;
      win_fill++;
      // window may hold more than the span after the length shrank
      while (win_fill > span)
         release_oldest();
      if (win_fill == span) begin
         hit = 1'b1;
         for (k = 0; k < span; k++)
            if (win_bytes[k] !== cfg_sep_bytes[8*k +: 8])
               hit = 1'b0;
         if (hit) begin
            emit_result(8'h00, 1'b0, 1'b1, 1'b0, '0);
            if (seps_found != TOTAL_MAX)
               seps_found++;
            for (k = trim; k < span; k++)
               emit_result(win_bytes[k], 1'b1, 1'b0, 1'b0, '0);
            win_fill = 0;
         end
      end
      // end of buffer: flush, then close with the record count
      if (last_in) begin
         total = (seps_found != TOTAL_MAX) ? seps_found + 1'b1 : TOTAL_MAX;
         while (win_fill > 0)
            release_oldest();
         emit_result(8'h00, 1'b0, 1'b1, 1'b1, total);
         seps_found = '0;
      end
   endtask

   task automatic check_field(input string name, input logic [TOTAL_W-1:0] got,
                              input logic [TOTAL_W-1:0] want);
      if (got !== want)
         report_error($sformatf("%s: got %0h, expected %0h", name, got, want));
   endtask

   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         report_error($sformatf("unexpected item: byte %02h valid %b eor %b eob %b",
                                rsp_out_byte, rsp_byte_valid, rsp_end_of_record,
                                rsp_end_of_buffer));
         return;
      end
      want = expected_results.pop_front();
      check_field("out_byte", TOTAL_W'(rsp_out_byte), TOTAL_W'(want.out_byte));
      check_field("byte_valid", TOTAL_W'(rsp_byte_valid), TOTAL_W'(want.byte_valid));
      check_field("end_of_record", TOTAL_W'(rsp_end_of_record),
                  TOTAL_W'(want.end_of_record));
      check_field("end_of_buffer", TOTAL_W'(rsp_end_of_buffer),
                  TOTAL_W'(want.end_of_buffer));
      check_field("record_total", rsp_record_total, want.record_total);
   endtask

   // Driver: offers pending bytes, with random gaps
   int              gap_left = 0;
   stream_byte_type next_byte;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            split_byte(req_data_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idle_div != 0 && $urandom_range(idle_div - 1) == 0) begin
               gap_left = $urandom_range(1, 19) - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               next_byte = pending_bytes.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= next_byte.data;
               req_last_byte <= next_byte.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks results, stalls in bursts or for one long hold
   int stall_left = 0;
   int hold_left  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_served != hold_request) begin
            hold_served = hold_request;
            hold_left   = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_div != 0 && $urandom_range(idle_div - 1) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles with no handshake at all
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Register write; the local copy follows on acceptance
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SEPARATOR_BYTES:  cfg_sep_bytes = value;
         CSR_SEPARATOR_LENGTH: cfg_sep_len   = value[CSR_LEN_W-1:0];
         CSR_TRIM_LENGTH:      cfg_trim_len  = value[CSR_LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic last);
      stream_byte_type sb;
      sb.data = b;
      sb.last = last;
      pending_bytes.push_back(sb);
      queued_total++;
   endtask

   // Wait until every byte is taken and every result has come, then settle
   task automatic drain();
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One random buffer: separators, partial separators and body bytes
   task automatic queue_buffer(input bit close);
      stream_byte_type rec_q[$];
      stream_byte_type sb;
      int              span;
      int              chunks;
      int              c;
      int              k;
      int              cut;
      span   = sep_span();
      chunks = $urandom_range(1, 12);
      sb.last = 1'b0;
      for (c = 0; c < chunks; c++) begin
         case ($urandom_range(0, 15))
            0, 1, 2, 3: cut = span;
            4, 5:       cut = $urandom_range(1, span);
            default:    cut = 0;
         endcase
         if (cut > 0) begin
            for (k = 0; k < cut; k++) begin
               sb.data = cfg_sep_bytes[8*k +: 8];
               rec_q.push_back(sb);
            end
         end else begin
            if ($urandom_range(0, 1) == 0)
               sb.data = 8'($urandom_range(0, 255));
            else
               sb.data = cfg_sep_bytes[8*$urandom_range(0, span - 1) +: 8];
            rec_q.push_back(sb);
         end
      end
      if (close)
         rec_q[rec_q.size() - 1].last = 1'b1;
      for (k = 0; k < rec_q.size(); k++)
         pending_bytes.push_back(rec_q[k]);
      queued_total += rec_q.size();
   endtask

   // Stimulus
   int                    phase_no;
   int                    n_bufs;
   int                    b;
   int                    new_len;
   int                    new_trim;
   bit                    closing_stretch;
   logic [CSR_DATA_W-1:0] junk;

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      idle_div = 6;

      // Reset settings: newline separator, trimmed; back-to-back separators
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h0A, 1'b0);
      queue_byte(8'h0A, 1'b1);
      queue_byte(8'h41, 1'b1);
      drain();

      // Two-byte separator kept whole; partial match at the buffer end
      write_reg(CSR_SEPARATOR_BYTES, 64'h0A0D);
      write_reg(CSR_SEPARATOR_LENGTH, 64'd2);
      write_reg(CSR_TRIM_LENGTH, 64'd0);
      queue_byte(8'h0D, 1'b0);
      queue_byte(8'h0A, 1'b0);
      queue_byte(8'h0D, 1'b0);
      queue_byte(8'h0A, 1'b0);
      queue_byte(8'h0D, 1'b1);
      drain();

      // Length above the window and trim above length, then shrink with bytes waiting
      write_reg(CSR_SEPARATOR_BYTES, 64'h0807060504030201);
      write_reg(CSR_SEPARATOR_LENGTH, 64'd12);
      write_reg(CSR_TRIM_LENGTH, 64'd15);
      for (b = 1; b <= 5; b++)
         queue_byte(b[7:0], 1'b0);
      drain();
      write_reg(CSR_SEPARATOR_LENGTH, 64'd3);
      write_reg(CSR_TRIM_LENGTH, 64'd1);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h02, 1'b0);
      queue_byte(8'h03, 1'b1);
      drain();

      // Zero length counts as one; unknown register index ignored
      write_reg(CSR_SEPARATOR_BYTES, '1);
      write_reg(CSR_SEPARATOR_LENGTH, 64'd0);
      write_reg(CSR_TRIM_LENGTH, 64'd0);
      write_reg(CSR_SPARE_INDEX, 64'h0123456789ABCDEF);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b1);
      drain();

      // Full-width separator of zero bytes, fully trimmed
      write_reg(CSR_SEPARATOR_BYTES, '0);
      write_reg(CSR_SEPARATOR_LENGTH, 64'd8);
      write_reg(CSR_TRIM_LENGTH, 64'd8);
      for (b = 0; b < 8; b++)
         queue_byte(8'h00, b == 7);
      drain();

      // Random phases, each under its own settings
      phase_no = 0;
      while (queued_total < ITEMS_TOTAL) begin
         closing_stretch = (queued_total > ITEMS_TOTAL - 90);
         if ($urandom_range(0, 9) == 0)
            new_len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
         else
            new_len = $urandom_range(1, SEP_MAX);
         if ($urandom_range(0, 9) == 0)
            new_trim = $urandom_range(0, 15);
         else
            new_trim = $urandom_range(0, (new_len > SEP_MAX) ? SEP_MAX : new_len);
         write_reg(CSR_SEPARATOR_BYTES, {$urandom, $urandom});
         junk = {$urandom, $urandom};
         write_reg(CSR_SEPARATOR_LENGTH, {junk[CSR_DATA_W-1:CSR_LEN_W], 4'(new_len)});
         junk = {$urandom, $urandom};
         write_reg(CSR_TRIM_LENGTH, {junk[CSR_DATA_W-1:CSR_LEN_W], 4'(new_trim)});
         if ($urandom_range(0, 5) == 0)
            write_reg(CSR_SPARE_INDEX, {$urandom, $urandom});

         case ($urandom_range(0, 2))
            0:       idle_div = 0;
            1:       idle_div = 3;
            default: idle_div = 8;
         endcase
         if (closing_stretch)
            idle_div = 0;
         // one long receiver hold while the sender keeps offering
         if (phase_no == 2) begin
            idle_div = 0;
            hold_request++;
         end

         n_bufs = $urandom_range(1, 4);
         for (b = 0; b < n_bufs; b++)
            queue_buffer((b < n_bufs - 1) || closing_stretch ||
                         ($urandom_range(0, 3) != 0));
         drain();
         phase_no++;
      end

      // Close any open buffer, then look for stray results
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
      drain();
      repeat (4 * DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_error($sformatf("%0d expected items never came", expected_results.size()));

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
